// ===== rtl/core/graph_permutation_compare_assert.svh =====
// Assertion macros for the graph compare RTL.
`ifndef GRAPH_PERMUTATION_COMPARE_ASSERT_SVH
`define GRAPH_PERMUTATION_COMPARE_ASSERT_SVH
`ifndef SYNTHESIS
`define GPC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gpc: same-cycle check failed");
`define GPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gpc: next-cycle check failed");
`else
`define GPC_ASSERT_SAME(label, clk, rst, ante, cons)
`define GPC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/gpc_pkg.sv =====
package gpc_pkg;

   localparam int MaxVertices = 64;
   localparam int VtxW        = $clog2(MaxVertices);
   localparam int CntW        = VtxW + 1;
   localparam int RowW        = MaxVertices;
   localparam int CmdW        = 3;
   localparam int ReqDataW    = 32;
   localparam int RspDataW    = 8;

   typedef enum logic [CmdW-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_QUERY  = 3'd2,
      CMD_MAP_A  = 3'd3,
      CMD_MAP_B  = 3'd4,
      CMD_AUTO   = 3'd5,
      CMD_CMP    = 3'd6,
      CMD_NOP    = 3'd7
   } cmd_type;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_QRY    = 8'b0000_0010,
      S_INS1   = 8'b0000_0100,
      S_INS2   = 8'b0000_1000,
      S_ROWMAP = 8'b0001_0000,
      S_ROWADJ = 8'b0010_0000,
      S_PAIR   = 8'b0100_0000,
      S_DONE   = 8'b1000_0000
   } state_type;

endpackage

// ===== rtl/core/graph_permutation_compare.sv =====
// Graph engine holding a symmetric adjacency bit matrix and two vertex maps, A and B, in
// synchronous memories. Each request beat is one command and gives one response beat.
// Clear, map writes, range errors and unused codes go straight to S_DONE, a query passes S_QRY,
// and an edge insert reads both rows at accept, then writes one row each in S_INS1 and S_INS2
// on the single write port. The automorphism check and the A<B compare walk the pairs i<j row
// by row: S_ROWMAP fetches the map entry of row i, S_ROWADJ the two rows and the map entries of
// column i+1, then S_PAIR checks one pair per cycle; a mismatch ends the walk early. Clear only
// resets the per-row valid flags, since each row carries one. Another request is taken only when
// the previous command has finished, and the response register frees the input side even while
// a response beat waits.
module graph_permutation_compare (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [gpc_pkg::CntW-1:0]         csr_wdata,     // vertices in use
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // command[2:0], vertex_u[8:3], vertex_v[14:9], map_slot[20:15], mapped_vertex[26:21]
   input  logic [gpc_pkg::ReqDataW-1:0]     req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [gpc_pkg::RspDataW-1:0]     rsp_tdata      // answer[0], range_error[1]
);
   import gpc_pkg::*;

   `include "graph_permutation_compare_assert.svh"

   // Request fields.
   cmd_type           req_cmd;
   logic [VtxW-1:0]   req_u, req_v, req_slot, req_mv;
   logic              req_fire;

   assign req_cmd  = cmd_type'(req_tdata[2:0]);
   assign req_u    = req_tdata[8:3];
   assign req_v    = req_tdata[14:9];
   assign req_slot = req_tdata[20:15];
   assign req_mv   = req_tdata[26:21];
   assign req_fire = req_tvalid && req_tready;

   // Control and working registers.
   state_type         state_ff, state_in;
   logic [CntW-1:0]   cnt_ff;
   logic [VtxW-1:0]   i_ff, i_in;
   logic [CntW-1:0]   j_ff, j_in;
   logic [CntW-1:0]   jd_ff, jd_in;
   logic              cmp_ff, cmp_in;
   logic [VtxW-1:0]   u_ff, u_in, v_ff, v_in;
   logic              ans_ff, ans_in, err_ff, err_in;
   logic [RowW-1:0]   row_valid_ff, row_valid_in;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_bits_ff;
   logic              rsp_load;

   // Memory ports.
   logic [RowW-1:0]   adj_mem [MaxVertices];
   logic [VtxW-1:0]   map_a_mem [MaxVertices];
   logic [VtxW-1:0]   map_b_mem [MaxVertices];
   logic [RowW-1:0]   q0_ff, q1_ff;
   logic              rv0_ff, rv1_ff;
   logic [VtxW-1:0]   ra0_ff, ra1_ff;
   logic [VtxW-1:0]   raddr0, raddr1;
   logic              adj_we;
   logic [VtxW-1:0]   adj_waddr;
   logic [RowW-1:0]   adj_wdata;
   logic [VtxW-1:0]   map_raddr;
   logic [VtxW-1:0]   ma_q_ff, mb_q_ff;
   logic              ma_we, mb_we;

   logic [CntW-1:0]   n_live;
   logic              uv_bad, map_bad;
   logic [RowW-1:0]   row0, row1;
   logic              bit_x, bit_y;

   assign n_live  = (cnt_ff > CntW'(MaxVertices)) ? CntW'(MaxVertices) : cnt_ff;
   assign uv_bad  = ({1'b0, req_u} >= n_live) || ({1'b0, req_v} >= n_live);
   assign map_bad = ({1'b0, req_slot} >= n_live) || ({1'b0, req_mv} >= n_live);

   // A row never written since the last clear reads as zero.
   assign row0 = q0_ff & {RowW{rv0_ff}};
   assign row1 = q1_ff & {RowW{rv1_ff}};

   // Automorphism: row i at column j against row a[i] at column a[j].
   // Compare: row a[i] at column a[j] against row b[i] at column b[j].
   assign bit_x = cmp_ff ? row0[ma_q_ff] : row0[jd_ff[VtxW-1:0]];
   assign bit_y = cmp_ff ? row1[mb_q_ff] : row1[ma_q_ff];

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      jd_in        = jd_ff;
      cmp_in       = cmp_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      ans_in       = ans_ff;
      err_in       = err_ff;
      row_valid_in = row_valid_ff;
      adj_we       = 1'b0;
      adj_waddr    = u_ff;
      adj_wdata    = row0 | (RowW'(1) << v_ff);
      ma_we        = 1'b0;
      mb_we        = 1'b0;
      raddr0       = ra0_ff;
      raddr1       = ra1_ff;
      map_raddr    = j_ff[VtxW-1:0];
      rsp_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            raddr0 = req_u;
            raddr1 = req_v;
            if (req_fire) begin
               u_in     = req_u;
               v_in     = req_v;
               ans_in   = 1'b0;
               err_in   = 1'b0;
               cmp_in   = (req_cmd == CMD_CMP);
               i_in     = '0;
               state_in = S_DONE;
               case (req_cmd)
                  CMD_CLEAR: begin
                     row_valid_in = '0;
                  end
                  CMD_INSERT: begin
                     if (uv_bad) err_in = 1'b1;
                     else state_in = S_INS1;
                  end
                  CMD_QUERY: begin
                     if (uv_bad) err_in = 1'b1;
                     else state_in = S_QRY;
                  end
                  CMD_MAP_A: begin
                     if (map_bad) err_in = 1'b1;
                     else ma_we = 1'b1;
                  end
                  CMD_MAP_B: begin
                     if (map_bad) err_in = 1'b1;
                     else mb_we = 1'b1;
                  end
                  CMD_AUTO, CMD_CMP: begin
                     // Verdict when no pair disagrees: equal for the check, not less for compare.
                     ans_in = (req_cmd == CMD_AUTO);
                     if (n_live >= CntW'(2)) state_in = S_ROWMAP;
                  end
                  default: ;
               endcase
            end
         end
         S_QRY: begin
            ans_in   = row0[v_ff];
            state_in = S_DONE;
         end
         S_INS1: begin
            adj_we          = 1'b1;
            adj_waddr       = u_ff;
            adj_wdata       = row0 | (RowW'(1) << v_ff);
            row_valid_in[u_ff] = 1'b1;
            state_in        = S_INS2;
         end
         S_INS2: begin
            // For a self loop this rewrites the same row with the same bit set.
            adj_we          = 1'b1;
            adj_waddr       = v_ff;
            adj_wdata       = row1 | (RowW'(1) << u_ff);
            row_valid_in[v_ff] = 1'b1;
            state_in        = S_DONE;
         end
         S_ROWMAP: begin
            map_raddr = i_ff;
            state_in  = S_ROWADJ;
         end
         S_ROWADJ: begin
            raddr0    = cmp_ff ? ma_q_ff : i_ff;
            raddr1    = cmp_ff ? mb_q_ff : ma_q_ff;
            map_raddr = i_ff + VtxW'(1);
            jd_in     = {1'b0, i_ff} + CntW'(1);
            j_in      = {1'b0, i_ff} + CntW'(2);
            state_in  = S_PAIR;
         end
         S_PAIR: begin
            // Map entries for column jd arrive now; the read for the next column goes out.
            map_raddr = j_ff[VtxW-1:0];
            jd_in     = j_ff;
            j_in      = j_ff + CntW'(1);
            if (bit_x != bit_y) begin
               ans_in   = cmp_ff & bit_y;
               state_in = S_DONE;
            end else if (jd_ff == n_live - CntW'(1)) begin
               if (({1'b0, i_ff} + CntW'(2)) >= n_live) begin
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + VtxW'(1);
                  state_in = S_ROWMAP;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         if (csr_we) cnt_ff <= csr_wdata;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      jd_ff  <= jd_in;
      cmp_ff <= cmp_in;
      u_ff   <= u_in;
      v_ff   <= v_in;
      ans_ff <= ans_in;
      err_ff <= err_in;
      ra0_ff <= raddr0;
      ra1_ff <= raddr1;
      if (rsp_load) rsp_bits_ff <= {err_ff, ans_ff};
   end

   // Adjacency memory: one write port, two registered read ports. A read of a row written in the
   // same cycle returns the old row, so inserts use only the rows as they stood at accept.
   always_ff @(posedge clock) begin
      if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
      q0_ff  <= adj_mem[raddr0];
      q1_ff  <= adj_mem[raddr1];
      rv0_ff <= row_valid_ff[raddr0];
      rv1_ff <= row_valid_ff[raddr1];
   end

   always_ff @(posedge clock) begin
      if (ma_we) map_a_mem[req_slot] <= req_mv;
      if (mb_we) map_b_mem[req_slot] <= req_mv;
      ma_q_ff <= map_a_mem[map_raddr];
      mb_q_ff <= map_b_mem[map_raddr];
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspDataW - 2){1'b0}}, rsp_bits_ff};

   `GPC_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, state_ff != S_IDLE)
   `GPC_ASSERT_SAME(a_pair_above_diag, clock, reset, state_ff == S_PAIR, jd_ff > {1'b0, i_ff})
   `GPC_ASSERT_SAME(a_err_clears_answer, clock, reset, rsp_valid_ff, !(&rsp_bits_ff))

endmodule

// ===== dv/graph_permutation_compare_checker.sv =====
module graph_permutation_compare_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [gpc_pkg::CntW-1:0]     csr_wdata,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [gpc_pkg::ReqDataW-1:0] req_tdata,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [gpc_pkg::RspDataW-1:0] rsp_tdata,
   output int                           fail_count,
   output int                           pending_count
);
   import gpc_pkg::*;

   typedef struct packed {
      logic answer;
      logic range_error;
   } verdict_type;

   typedef struct {
      cmd_type     command;
      verdict_type verdict;
   } awaited_type;

   logic [RowW-1:0] adjacency [MaxVertices];
   logic [VtxW-1:0] map_a [MaxVertices];
   logic [VtxW-1:0] map_b [MaxVertices];
   logic [CntW-1:0] count_setting;
   awaited_type     awaited_results [$];

   function automatic int vertices_in_use();
      return (count_setting > MaxVertices) ? MaxVertices : int'(count_setting);
   endfunction

   // Applies one command to the local copy of the graph and returns its verdict.
   function automatic verdict_type run_graph_command(cmd_type cmd, logic [VtxW-1:0] u,
         logic [VtxW-1:0] v, logic [VtxW-1:0] slot, logic [VtxW-1:0] mv);
      verdict_type r;
      int n, i, j;
      logic x, y;
      bit done;
      r = '0;
      n = vertices_in_use();
      done = 1'b0;
      case (cmd)
         CMD_CLEAR: begin
            foreach (adjacency[k]) adjacency[k] = '0;
         end
         CMD_INSERT: begin
            if (u >= n || v >= n) begin
               r.range_error = 1'b1;
            end else begin
               adjacency[u][v] = 1'b1;
               adjacency[v][u] = 1'b1;
            end
         end
         CMD_QUERY: begin
            if (u >= n || v >= n) r.range_error = 1'b1;
            else r.answer = adjacency[u][v];
         end
         CMD_MAP_A, CMD_MAP_B: begin
            if (slot >= n || mv >= n) r.range_error = 1'b1;
            else if (cmd == CMD_MAP_A) map_a[slot] = mv;
            else map_b[slot] = mv;
         end
         CMD_AUTO: begin
            r.answer = 1'b1;
            for (i = 0; i < n && r.answer; i++) begin
               for (j = i + 1; j < n; j++) begin
                  if (adjacency[i][j] != adjacency[map_a[i]][map_a[j]]) begin
                     r.answer = 1'b0;
                     break;
                  end
               end
            end
         end
         CMD_CMP: begin
            // The first pair in row order where the two relabeled matrices differ decides.
            for (i = 0; i < n && !done; i++) begin
               for (j = i + 1; j < n; j++) begin
                  x = adjacency[map_a[i]][map_a[j]];
                  y = adjacency[map_b[i]][map_b[j]];
                  if (x != y) begin
                     r.answer = (x < y);
                     done = 1'b1;
                     break;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   task automatic report_failure(string what, verdict_type want, verdict_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] %s: expected answer=%0b range_error=%0b, got %0b %0b",
                  $realtime, what, want.answer, want.range_error, got.answer, got.range_error);
   endtask

   always @(posedge clock) begin
      verdict_type got;
      awaited_type oldest;
      awaited_type fresh;
      if (reset) begin
         foreach (adjacency[k]) adjacency[k] = '0;
         foreach (map_a[k]) begin
            map_a[k] = '0;
            map_b[k] = '0;
         end
         count_setting = '0;
         awaited_results.delete();
         fail_count = 0;
      end else begin
         // A response beat always belongs to an earlier command, so it is matched first.
         if (rsp_tvalid && rsp_tready) begin
            got.answer = rsp_tdata[0];
            got.range_error = rsp_tdata[1];
            if (awaited_results.size() == 0) begin
               report_failure("response beat with no command outstanding", '0, got);
            end else begin
               oldest = awaited_results.pop_front();
               if (got.answer !== oldest.verdict.answer ||
                   got.range_error !== oldest.verdict.range_error)
                  report_failure($sformatf("%s result mismatch", oldest.command.name()),
                                 oldest.verdict, got);
            end
         end
         if (req_tvalid && req_tready) begin
            fresh.command = cmd_type'(req_tdata[2:0]);
            fresh.verdict = run_graph_command(fresh.command, req_tdata[8:3], req_tdata[14:9],
                                              req_tdata[20:15], req_tdata[26:21]);
            awaited_results = {awaited_results, fresh};
         end
         if (csr_we) count_setting = csr_wdata;
      end
      pending_count = awaited_results.size();
   end

endmodule

// ===== dv/graph_permutation_compare_tb.sv =====
module graph_permutation_compare_tb;
   import gpc_pkg::*;

   localparam int WatchdogLimit = 10000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_we = 1'b0;
   logic [CntW-1:0]     csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   int items_sent = 0;
   int walks_sent = 0;
   int settings_used = 1;
   int stall_left = 0;
   int calm_left = 0;
   int live_n = 0;
   bit calm = 1'b0;
   bit written_a [MaxVertices];
   bit written_b [MaxVertices];

   graph_permutation_compare dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   graph_permutation_compare_checker graph_check (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly in range, now and then anywhere in the 6-bit field.
   function automatic int pick_vertex();
      if (live_n > 0 && $urandom_range(0, 9) != 0) return $urandom_range(0, live_n - 1);
      return $urandom_range(0, 63);
   endfunction

   function automatic bit maps_loaded();
      for (int s = 0; s < live_n; s++)
         if (!written_a[s] || !written_b[s]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void scramble(ref int perm [MaxVertices], input int n, input bit full);
      int i, k, t;
      if (n < 2) return;
      if (full) begin
         for (i = n - 1; i > 0; i--) begin
            k = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[k];
            perm[k] = t;
         end
      end else begin
         i = $urandom_range(0, n - 1);
         k = $urandom_range(0, n - 1);
         t = perm[i];
         perm[i] = perm[k];
         perm[k] = t;
      end
   endfunction

   // Called at a rising edge; returns at the edge where the beat was taken.
   task automatic send_command(cmd_type cmd, int u, int v, int slot, int mv);
      int gap;
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, 6'(mv), 6'(slot), 6'(v), 6'(u), cmd};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (cmd == CMD_AUTO || cmd == CMD_CMP) walks_sent++;
      if ((cmd == CMD_MAP_A || cmd == CMD_MAP_B) && slot < live_n && mv < live_n) begin
         if (cmd == CMD_MAP_A) written_a[slot] = 1'b1;
         else written_b[slot] = 1'b1;
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      @(posedge clock);
   endtask

   task automatic write_count_setting(int value);
      csr_we <= 1'b1;
      csr_wdata <= CntW'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      live_n = (value > MaxVertices) ? MaxVertices : value;
      settings_used++;
   endtask

   task automatic load_maps();
      int perm_a [MaxVertices];
      int perm_b [MaxVertices];
      int s;
      for (s = 0; s < MaxVertices; s++) perm_a[s] = s;
      case ($urandom_range(0, 2))
         0: ;
         1: scramble(perm_a, live_n, 1'b0);
         default: scramble(perm_a, live_n, 1'b1);
      endcase
      // B usually equals A or differs by one swap, so compares walk far.
      perm_b = perm_a;
      case ($urandom_range(0, 3))
         0, 1: ;
         2: scramble(perm_b, live_n, 1'b0);
         default: scramble(perm_b, live_n, 1'b1);
      endcase
      for (s = 0; s < live_n; s++)
         send_command(CMD_MAP_A, $urandom_range(0, 63), $urandom_range(0, 63), s, perm_a[s]);
      for (s = 0; s < live_n; s++)
         send_command(CMD_MAP_B, $urandom_range(0, 63), $urandom_range(0, 63), s, perm_b[s]);
   endtask

   task automatic run_phase(int count_value, int edges, int ops);
      drain();
      write_count_setting(count_value);
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0)
         send_command(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 63), $urandom_range(0, 63));
      repeat (edges)
         send_command(CMD_INSERT, pick_vertex(), pick_vertex(),
                      $urandom_range(0, 63), $urandom_range(0, 63));
      if (!maps_loaded() || (live_n < 32 && $urandom_range(0, 1) == 1)) load_maps();
      repeat (ops) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_command(CMD_AUTO, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 63), $urandom_range(0, 63));
            3, 4, 5: send_command(CMD_CMP, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 63), $urandom_range(0, 63));
            6, 7: send_command(CMD_QUERY, pick_vertex(), pick_vertex(),
                               $urandom_range(0, 63), $urandom_range(0, 63));
            8: begin
               if ($urandom_range(0, 1) == 1)
                  send_command(CMD_NOP, $urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 63), $urandom_range(0, 63));
               else
                  send_command($urandom_range(0, 1) ? CMD_MAP_A : CMD_MAP_B,
                               $urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 63), $urandom_range(0, 63));
            end
            default: send_command(CMD_INSERT, pick_vertex(), pick_vertex(),
                                  $urandom_range(0, 63), $urandom_range(0, 63));
         endcase
      end
   endtask

   // Response side: random stalls, with the occasional long stretch of steady ready.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (calm_left > 0) calm_left <= calm_left - 1;
         else if ($urandom_range(0, 199) == 0) calm_left <= $urandom_range(50, 300);
         else if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WatchdogLimit) begin
         $display("Timeout: no beat moved for %0d cycles", WatchdogLimit);
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int count;
      int r;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // No vertices in use: walks are empty and every index is out of range.
      send_command(CMD_AUTO, 0, 0, 0, 0);
      send_command(CMD_CMP, 0, 0, 0, 0);
      send_command(CMD_INSERT, 0, 0, 0, 0);
      send_command(CMD_NOP, 63, 63, 63, 63);
      drain();
      write_count_setting(4);
      send_command(CMD_INSERT, 0, 3, 0, 0);
      send_command(CMD_INSERT, 2, 2, 0, 0);
      send_command(CMD_INSERT, 1, 4, 0, 0);
      send_command(CMD_QUERY, 3, 0, 0, 0);
      send_command(CMD_QUERY, 2, 2, 0, 0);
      send_command(CMD_QUERY, 5, 0, 0, 0);
      send_command(CMD_MAP_A, 0, 0, 4, 0);
      send_command(CMD_MAP_B, 0, 0, 0, 63);
      for (int s = 0; s < 4; s++) send_command(CMD_MAP_A, 0, 0, s, s);
      for (int s = 0; s < 4; s++) send_command(CMD_MAP_B, 0, 0, s, (s < 2) ? 1 - s : s);
      send_command(CMD_AUTO, 0, 0, 0, 0);
      send_command(CMD_CMP, 0, 0, 0, 0);
      send_command(CMD_CLEAR, 0, 0, 0, 0);
      send_command(CMD_QUERY, 0, 3, 0, 0);

      run_phase(64, 40, 12);
      run_phase(127, 10, 10);
      run_phase(1, 3, 6);
      run_phase(2, 3, 8);
      while (items_sent < 290) begin
         r = $urandom_range(0, 9);
         if (r == 0) count = 0;
         else if (r == 1) count = $urandom_range(65, 127);
         else count = $urandom_range(3, 20);
         run_phase(count, $urandom_range(2, 12), $urandom_range(6, 14));
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Ran %0d commands, %0d of them triangle walks, over %0d vertex-count settings.",
               items_sent, walks_sent, settings_used);
      $display("Mismatches seen: %0d", fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
